FILE: src/jeo_pkg.sv
// ----------------------------------------------------------------------------
// jeo_pkg
// Shared widths, register indices and control structures of the
// elimination order block.
// ----------------------------------------------------------------------------
package jeo_pkg;

  localparam int unsigned POS_W  = 7;  // ring size, start and removed person
  localparam int unsigned STEP_W = 8;
  localparam int unsigned CFG_W  = 8;  // widest register
  localparam int unsigned IDX_W  = 2;

  localparam logic [IDX_W-1:0] CFG_RING_SIZE      = 2'd0;
  localparam logic [IDX_W-1:0] CFG_STEP_COUNT     = 2'd1;
  localparam logic [IDX_W-1:0] CFG_START_POSITION = 2'd2;

  localparam logic [POS_W-1:0]  RING_SIZE_RST      = 7'd8;
  localparam logic [STEP_W-1:0] STEP_COUNT_RST     = 8'd3;
  localparam logic [POS_W-1:0]  START_POSITION_RST = 7'd1;

  typedef struct packed {
    logic load;        // take a new request
    logic mod_step;    // one subtraction of the start reduction
    logic count_step;  // move one place and count a survivor
    logic emit;        // remove the current person and send the word
    logic skip_step;   // move one place past a removed person
  } jeo_cmd_t;

  typedef struct packed {
    logic n_zero;      // configured ring is empty
    logic mod_done;    // start reduced below the ring size
    logic k_done;      // count has reached the step
    logic alive_cur;   // person at the current place is still in
    logic last;        // one person left
    logic rem_zero;
    logic out_free;    // output register can take a word
  } jeo_sts_t;

endpackage

FILE: src/jeo_req_if.sv
// ----------------------------------------------------------------------------
// jeo_req_if
// Request channel: one word carries the counting direction.
// ----------------------------------------------------------------------------
interface jeo_req_if;
  logic valid;
  logic ready;
  logic direction;

  modport source (output valid, output direction, input ready);
  modport sink   (input valid, input direction, output ready);
endinterface

FILE: src/jeo_res_if.sv
// ----------------------------------------------------------------------------
// jeo_res_if
// Result channel: one word per removed person.
// ----------------------------------------------------------------------------
interface jeo_res_if;
  logic                      valid;
  logic                      ready;
  logic [jeo_pkg::POS_W-1:0] removed_position;
  logic                      last_of_run;

  modport source (output valid, output removed_position, output last_of_run, input ready);
  modport sink   (input valid, input removed_position, input last_of_run, output ready);
endinterface

FILE: src/josephus_elimination_order.sv
// ----------------------------------------------------------------------------
// josephus_elimination_order
// Emits the removal order of a counting-out ring, one word per person.
// ----------------------------------------------------------------------------
// Each request word picks a direction and empties a ring of
// min(ring_size, MAX_PEOPLE) people, returning one result word per removal,
// the final one marked with last_of_run; a ring size of zero returns nothing.
// A request is loaded, then runs the subtractions of the start reduction
// (start_position - 1, up to 126, reduced by the ring size), then per
// removal the counting loop, which moves one place at a time and ends on a
// check, and the removal itself, and after every removal but the last a skip
// over dead places that also ends on a check. The walk grows longer as
// removed places thin the ring, since the current position steps one place
// at a time over the alive bitmap.
// The removal waits while the output register is full. A new request is
// taken once the previous one has sent its last word to the output register.
// Registers are to be written only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module josephus_elimination_order #(
  parameter int unsigned MAX_PEOPLE = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [jeo_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [jeo_pkg::CFG_W-1:0]  cfg_data_i,
  jeo_req_if.sink                    req_i,
  jeo_res_if.source                  res_o
);

  logic [jeo_pkg::POS_W-1:0]  ring_size_q;
  logic [jeo_pkg::STEP_W-1:0] step_count_q;
  logic [jeo_pkg::POS_W-1:0]  start_position_q;

  jeo_pkg::jeo_cmd_t cmd;
  jeo_pkg::jeo_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q      <= jeo_pkg::RING_SIZE_RST;
      step_count_q     <= jeo_pkg::STEP_COUNT_RST;
      start_position_q <= jeo_pkg::START_POSITION_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jeo_pkg::CFG_RING_SIZE:      ring_size_q      <= cfg_data_i[jeo_pkg::POS_W-1:0];
        jeo_pkg::CFG_STEP_COUNT:     step_count_q     <= cfg_data_i;
        jeo_pkg::CFG_START_POSITION: start_position_q <= cfg_data_i[jeo_pkg::POS_W-1:0];
        default: ;
      endcase
    end
  end

  jeo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  jeo_datapath #(
    .MAX_PEOPLE (MAX_PEOPLE)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ring_size_i      (ring_size_q),
    .step_count_i     (step_count_q),
    .start_position_i (start_position_q),
    .direction_i      (req_i.direction),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .res_ready_i      (res_o.ready),
    .res_valid_o      (res_o.valid),
    .res_pos_o        (res_o.removed_position),
    .res_last_o       (res_o.last_of_run)
  );

endmodule

FILE: src/jeo_datapath.sv
// ----------------------------------------------------------------------------
// jeo_datapath
// Alive bitmap, current place, counters and the output register.
// ----------------------------------------------------------------------------
module jeo_datapath #(
  parameter int unsigned MAX_PEOPLE = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [jeo_pkg::POS_W-1:0]  ring_size_i,
  input  logic [jeo_pkg::STEP_W-1:0] step_count_i,
  input  logic [jeo_pkg::POS_W-1:0]  start_position_i,
  input  logic                       direction_i,
  input  jeo_pkg::jeo_cmd_t          cmd_i,
  output jeo_pkg::jeo_sts_t          sts_o,
  input  logic                       res_ready_i,
  output logic                       res_valid_o,
  output logic [jeo_pkg::POS_W-1:0]  res_pos_o,
  output logic                       res_last_o
);

  localparam int unsigned PW = $clog2(MAX_PEOPLE);
  localparam int unsigned CW = $clog2(MAX_PEOPLE + 1);

  logic [MAX_PEOPLE-1:0]      alive_q, alive_d;
  logic [PW-1:0]              pos_q, pos_d, pos_adv;
  logic [CW-1:0]              n_q, n_d, n_cfg;
  logic [CW-1:0]              rem_q, rem_d;
  logic [jeo_pkg::POS_W-1:0]  mod_q, mod_d;
  logic [jeo_pkg::STEP_W-1:0] k_q, k_d;
  logic                       dir_q, dir_d;
  logic                       out_valid_q, out_valid_d;
  logic [jeo_pkg::POS_W-1:0]  out_pos_q, out_pos_d;
  logic                       out_last_q, out_last_d;
  logic [CW-1:0]              pos_ext;
  logic                       adv_alive;

  assign n_cfg = (ring_size_i > jeo_pkg::POS_W'(MAX_PEOPLE)) ? CW'(MAX_PEOPLE)
                                                             : CW'(ring_size_i);
  assign pos_ext = CW'(pos_q);

  // One place on round the ring, wrapping at either end.
  always_comb begin
    if (dir_q) begin
      pos_adv = (pos_q == '0) ? PW'(n_q - CW'(1)) : PW'(pos_ext - CW'(1));
    end else begin
      pos_adv = (pos_ext + CW'(1) >= n_q) ? '0 : PW'(pos_ext + CW'(1));
    end
  end

  assign adv_alive = alive_q[pos_adv];

  always_comb begin
    alive_d     = alive_q;
    pos_d       = pos_q;
    n_d         = n_q;
    rem_d       = rem_q;
    mod_d       = mod_q;
    k_d         = k_q;
    dir_d       = dir_q;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !res_ready_i;
    if (cmd_i.load) begin
      for (int i = 0; i < MAX_PEOPLE; i++) begin
        alive_d[i] = (CW'(i) < n_cfg);
      end
      n_d   = n_cfg;
      rem_d = n_cfg;
      dir_d = direction_i;
      k_d   = jeo_pkg::STEP_W'(1);
      mod_d = (start_position_i == '0) ? '0 : start_position_i - jeo_pkg::POS_W'(1);
    end
    if (cmd_i.mod_step) begin
      if (sts_o.mod_done) begin
        pos_d = mod_q[PW-1:0];
      end else begin
        mod_d = mod_q - jeo_pkg::POS_W'(n_q);
      end
    end
    if (cmd_i.count_step) begin
      pos_d = pos_adv;
      if (adv_alive) begin
        k_d = k_q + jeo_pkg::STEP_W'(1);
      end
    end
    if (cmd_i.skip_step) begin
      pos_d = pos_adv;
    end
    if (cmd_i.emit) begin
      alive_d[pos_q] = 1'b0;
      rem_d          = rem_q - CW'(1);
      k_d            = jeo_pkg::STEP_W'(1);
      out_valid_d    = 1'b1;
      out_pos_d      = jeo_pkg::POS_W'(pos_ext) + jeo_pkg::POS_W'(1);
      out_last_d     = (rem_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      n_q         <= '0;
      k_q         <= '0;
      pos_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
      n_q         <= n_d;
      k_q         <= k_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    alive_q    <= alive_d;
    mod_q      <= mod_d;
    dir_q      <= dir_d;
    out_pos_q  <= out_pos_d;
    out_last_q <= out_last_d;
  end

  always_comb begin
    sts_o.n_zero    = (ring_size_i == '0);
    sts_o.mod_done  = (mod_q < jeo_pkg::POS_W'(n_q));
    sts_o.k_done    = (k_q >= step_count_i);
    sts_o.alive_cur = alive_q[pos_q];
    sts_o.last      = (rem_q == CW'(1));
    sts_o.rem_zero  = (rem_q == '0);
    sts_o.out_free  = !out_valid_q || res_ready_i;
  end

  assign res_valid_o = out_valid_q;
  assign res_pos_o   = out_pos_q;
  assign res_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_pos_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.count_step |-> (pos_ext < n_q))
    else $error("current place outside the ring while counting");
  a_rem_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && !cmd_i.load) |=> (rem_q == $past(rem_q) - CW'(1)))
    else $error("remaining count not reduced by a removal");
`endif

endmodule

FILE: src/jeo_ctrl.sv
// ----------------------------------------------------------------------------
// jeo_ctrl
// Sequencer of one request: start reduction, counting, removal, skipping.
// ----------------------------------------------------------------------------
module jeo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  jeo_pkg::jeo_sts_t sts_i,
  output jeo_pkg::jeo_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_COUNT,
    ST_EMIT,
    ST_SKIP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          // An empty ring yields no words at all.
          if (!sts_i.n_zero) begin
            state_d = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_done) begin
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (sts_i.k_done) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.count_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.last ? ST_IDLE : ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts_i.alive_cur) begin
          state_d = ST_COUNT;
        end else begin
          cmd_o.skip_step = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_count_has_people: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COUNT) |-> !sts_i.rem_zero)
    else $error("counting with nobody left in the ring");
  a_remove_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.alive_cur)
    else $error("removing a person who is already out");
`endif

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the counting-out ring that emits its removal order.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the three ring registers and computes the
// full removal order of every accepted request. Each result word is checked
// against the oldest word still waiting. Directed tests cover the reset
// settings, the register extremes, the empty, oversized and single-person
// rings, start wrapping and a step of zero. Random phases follow, with idle
// bursts on both channels, a long receiver hold-off and a final phase with
// no idling at all.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned RING_MAX     = 64;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT  = 10000000;
  localparam int unsigned PRINT_LIMIT  = 40;

  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  // Index 3 is not mapped to any register.
  localparam logic [jeo_pkg::IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct {
    logic [jeo_pkg::POS_W-1:0] removed_position;
    logic                      last_of_run;
  } removal_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [jeo_pkg::IDX_W-1:0] cfg_idx;
  logic [jeo_pkg::CFG_W-1:0] cfg_data;

  jeo_req_if req_if ();
  jeo_res_if res_if ();

  josephus_elimination_order DUT (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i     (req_if),
    .res_o     (res_if)
  );

  // Bench copy of the registers, updated on every write.
  logic [jeo_pkg::POS_W-1:0]  ring_cfg;
  logic [jeo_pkg::STEP_W-1:0] step_cfg;
  logic [jeo_pkg::POS_W-1:0]  start_cfg;

  removal_t removal_q[$];

  int  mismatch_count;
  int  cycle_count;
  int  stall_left;
  bit  src_idle_en;
  bit  sink_idle_en;
  logic res_hold;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int next_place(input int pos, input int ring, input logic dir);
    if (dir == DIR_DOWN) begin
      return (pos == 0) ? ring - 1 : pos - 1;
    end
    return (pos + 1 >= ring) ? 0 : pos + 1;
  endfunction

  // Works out the whole removal order of one request.
  task automatic predict_removals(input logic dir);
    logic [RING_MAX-1:0] alive;
    removal_t            word;
    int                  ring;
    int                  cur;
    int                  left;
    int                  k;
    ring = int'(ring_cfg);
    if (ring == 0) return;
    if (ring > RING_MAX) ring = RING_MAX;
    alive = (ring >= RING_MAX) ? '1 : ((64'd1 << ring) - 64'd1);
    cur   = (start_cfg == 0) ? 0 : (int'(start_cfg) - 1) % ring;
    left  = ring;
    while (left != 0) begin
      k = 1;
      while (k < int'(step_cfg)) begin
        cur = next_place(cur, ring, dir);
        if (alive[cur]) k++;
      end
      alive[cur] = 1'b0;
      left--;
      word.removed_position = jeo_pkg::POS_W'(cur + 1);
      word.last_of_run      = (left == 0);
      removal_q.push_back(word);
      while (left != 0 && !alive[cur]) cur = next_place(cur, ring, dir);
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("ERROR @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_removal(input logic [jeo_pkg::POS_W-1:0] pos, input logic last);
    removal_t exp;
    if (removal_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word position=%0d last=%0b", pos, last));
      return;
    end
    exp = removal_q.pop_front();
    if (pos !== exp.removed_position)
      report_mismatch($sformatf("removed_position %0d, expected %0d",
                                pos, exp.removed_position));
    if (last !== exp.last_of_run)
      report_mismatch($sformatf("last_of_run %0b, expected %0b at position %0d",
                                last, exp.last_of_run, exp.removed_position));
  endtask

  // Called at a rising edge; returns at the edge where the word is accepted.
  // Valid is left high so that a following word goes out without a gap.
  task automatic send_request(input logic dir);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.direction <= dir;
    do @(posedge clk); while (!req_if.ready);
    predict_removals(dir);
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (removal_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high; program_ring lowers it.
  task automatic drive_reg(input logic [jeo_pkg::IDX_W-1:0] idx,
                           input logic [jeo_pkg::CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      jeo_pkg::CFG_RING_SIZE:      ring_cfg  = data[jeo_pkg::POS_W-1:0];
      jeo_pkg::CFG_STEP_COUNT:     step_cfg  = data;
      jeo_pkg::CFG_START_POSITION: start_cfg = data[jeo_pkg::POS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_ring(input logic [jeo_pkg::CFG_W-1:0] ring,
                              input logic [jeo_pkg::CFG_W-1:0] step,
                              input logic [jeo_pkg::CFG_W-1:0] start);
    drive_reg(jeo_pkg::CFG_RING_SIZE, ring);
    drive_reg(jeo_pkg::CFG_STEP_COUNT, step);
    drive_reg(jeo_pkg::CFG_START_POSITION, start);
    cfg_we <= 1'b0;
  endtask

  // Result side: check accepted words and idle in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready)
        check_removal(res_if.removed_position, res_if.last_of_run);
      if (res_hold) begin
        res_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_request(DIR_UP);
    send_request(DIR_DOWN);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    program_ring(8'd1, 8'd1, 8'd1);
    send_request(DIR_UP);
    send_request(DIR_DOWN);
    wait_idle();
    program_ring(8'd64, 8'd255, 8'd64);
    send_request(DIR_UP);
    send_request(DIR_DOWN);
    wait_idle();
    program_ring(8'd64, 8'd1, 8'd1);
    send_request(DIR_DOWN);
    wait_idle();
    program_ring(8'd2, 8'd255, 8'd2);
    send_request(DIR_UP);
    send_request(DIR_DOWN);
    wait_idle();
  endtask

  // The top bit of the data is dropped, so 8'hFF gives a ring of 127.
  task automatic test_oversized_ring();
    program_ring(8'hFF, 8'd2, 8'd127);
    send_request(DIR_DOWN);
    wait_idle();
    program_ring(8'hC1, 8'd5, 8'hFF);
    send_request(DIR_UP);
    wait_idle();
  endtask

  task automatic test_start_and_step_cases();
    // The start lies beyond the ring and wraps round it.
    program_ring(8'd5, 8'd4, 8'd64);
    send_request(DIR_UP);
    send_request(DIR_DOWN);
    wait_idle();
    // A start of zero begins at person 1; a step of zero removes at once.
    program_ring(8'd7, 8'd0, 8'd0);
    send_request(DIR_UP);
    send_request(DIR_DOWN);
    wait_idle();
  endtask

  task automatic test_empty_ring();
    drive_reg(CFG_UNUSED_IDX, 8'hFF);
    program_ring(8'd0, 8'd9, 8'd3);
    send_request(DIR_UP);
    send_request(DIR_DOWN);
    wait_idle();
    program_ring(8'd3, 8'd2, 8'd2);
    send_request(DIR_DOWN);
    wait_idle();
  endtask

  task automatic run_random_phases(input int items);
    int   sent;
    int   burst;
    int   pick;
    logic [jeo_pkg::CFG_W-1:0] ring;
    logic [jeo_pkg::CFG_W-1:0] step;
    logic [jeo_pkg::CFG_W-1:0] start;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      ring = 8'd0;
      else if (pick == 1) ring = 8'($urandom_range(65, 127));
      else if (pick <= 3) ring = 8'($urandom_range(17, 64));
      else                ring = 8'($urandom_range(1, 16));
      // Large rings get small steps to keep the run short.
      if (ring > 16 || ring == 0) step = 8'($urandom_range(0, 12));
      else if ($urandom_range(0, 9) == 0) step = 8'($urandom_range(0, 255));
      else step = 8'($urandom_range(0, 20));
      start = 8'($urandom_range(0, 127));
      // Junk in the unused top bit must be ignored.
      ring[jeo_pkg::CFG_W-1]  = 1'($urandom_range(0, 1));
      start[jeo_pkg::CFG_W-1] = 1'($urandom_range(0, 1));
      wait_idle();
      program_ring(ring, step, start);
      burst = $urandom_range(3, 10);
      repeat (burst) begin
        send_request(logic'($urandom_range(0, 1)));
        sent++;
      end
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    program_ring(8'd8, 8'd3, 8'd1);
    fork
      begin
        res_hold <= 1'b1;
        repeat (400) @(posedge clk);
        res_hold <= 1'b0;
      end
    join_none
    repeat (6) send_request(logic'($urandom_range(0, 1)));
    // Pause the sender until every outstanding word has come back.
    req_if.valid <= 1'b0;
    while (removal_q.size() != 0) @(posedge clk);
    send_request(DIR_UP);
    send_request(DIR_DOWN);
    wait_idle();
  endtask

  task automatic test_no_idling();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_random_phases(20);
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    req_if.valid    = 1'b0;
    req_if.direction = DIR_UP;
    res_if.ready    = 1'b0;
    res_hold        = 1'b0;
    stall_left      = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    src_idle_en     = 1'b1;
    sink_idle_en    = 1'b1;
    ring_cfg        = jeo_pkg::RING_SIZE_RST;
    step_cfg        = jeo_pkg::STEP_COUNT_RST;
    start_cfg       = jeo_pkg::START_POSITION_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_oversized_ring();
    test_start_and_step_cases();
    test_empty_ring();
    run_random_phases(85);
    test_backpressure();
    test_no_idling();

    wait_idle();
    if (mismatch_count == 0 && removal_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: josephus_elimination_order.f
src/jeo_pkg.sv
src/jeo_req_if.sv
src/jeo_res_if.sv
src/jeo_datapath.sv
src/jeo_ctrl.sv
src/josephus_elimination_order.sv
tb/tb_top.sv
